/* rtl/gf256_erasure_parity_encoder_macros.svh */
// Assertion macros shared by the checker of the GF(2^8) erasure parity encoder.
// No dependencies; included by the checker file.
`ifndef GF256_ERASURE_PARITY_ENCODER_MACROS_SVH
`define GF256_ERASURE_PARITY_ENCODER_MACROS_SVH

// Clocked property that is ignored while reset is asserted.
`define GFPE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define GFPE_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gfpe_pkg.sv */
// Shared types, constants and GF(2^8) tables for the erasure parity encoder.
// No dependencies; used by every design module of the block.
package gfpe_pkg;

  localparam int PARITY_MAX_DEF = 16;
  localparam int FRAG_W         = 8;
  localparam int COL_W          = 16;
  localparam int DATA_W         = 8;
  localparam int PCNT_W         = 5;
  localparam int IDX_OUT_W      = 4;
  localparam int CFG_IDX_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LANE_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH = 4'd1;

  localparam logic [PCNT_W-1:0] PCNT_RESET = 5'd1;
  localparam logic [COL_W-1:0]  BW_RESET   = 16'd1024;

  localparam logic [8:0] GF_POLY = 9'h11D;

  typedef logic [7:0] gf_tbl_t [256];

  // Antilog table: entry i holds alpha^i, alpha = 2.
  function automatic gf_tbl_t build_exp();
    gf_tbl_t    t;
    logic [8:0] x;
    x = 9'd1;
    for (int i = 0; i < 256; i++) begin
      t[i] = x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return t;
  endfunction

  // Log table: entry x holds i with alpha^i = x. Entry zero is unused.
  function automatic gf_tbl_t build_log();
    gf_tbl_t    t;
    logic [8:0] x;
    t[0] = 8'd0;
    x = 9'd1;
    for (int i = 0; i < 255; i++) begin
      t[x[7:0]] = 8'(i);
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return t;
  endfunction

  localparam gf_tbl_t EXP_TBL = build_exp();
  localparam gf_tbl_t LOG_TBL = build_log();

  // Reduces a sum of logarithms modulo 255 by folding the high byte twice.
  function automatic logic [7:0] mod255(input logic [14:0] x);
    logic [8:0] s;
    logic [7:0] r;
    s = {2'b00, x[14:8]} + {1'b0, x[7:0]};
    r = s[7:0] + {7'd0, s[8]};
    return (r == 8'hFF) ? 8'd0 : r;
  endfunction

  // Control from the input stage to the accumulator bank.
  typedef struct packed {
    logic fire;   // an in-range item leaves the input stage
    logic close;  // that item closes the column
  } acc_ctl_t;

endpackage

/* rtl/gfpe_lane.sv */
// One parity lane multiplier: data times (j+1)^LANE in GF(2^8) via log tables.
// Depends on gfpe_pkg.
module gfpe_lane #(
  parameter int LANE = 0
) (
  input  logic [7:0] log_base,
  input  logic [7:0] log_data,
  input  logic       base_zero,
  input  logic       data_zero,
  output logic [7:0] prod
);

  localparam logic [14:0] LANE_K = 15'(LANE);

  logic [14:0] log_sum;
  logic [7:0]  exp_idx;

  // log(c * d) = LANE * log(base) + log(data), modulo 255.
  assign log_sum = LANE_K * {7'd0, log_base} + {7'd0, log_data};
  assign exp_idx = gfpe_pkg::mod255(log_sum);

  always_comb begin
    if (data_zero) begin
      prod = 8'd0;
    end else if (base_zero && (LANE != 0)) begin
      prod = 8'd0;
    end else begin
      prod = gfpe_pkg::EXP_TBL[exp_idx];
    end
  end

endmodule

/* rtl/gfpe_accum.sv */
// Parity accumulator bank: all lanes multiply and XOR in parallel, combinationally.
// Depends on gfpe_pkg and gfpe_lane.
module gfpe_accum #(
  parameter int PARITY_MAX = gfpe_pkg::PARITY_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gfpe_pkg::acc_ctl_t          ctl,
  input  logic [gfpe_pkg::FRAG_W-1:0] frag,
  input  logic [gfpe_pkg::DATA_W-1:0] data,
  output logic [7:0]                  sum [PARITY_MAX]
);

  logic [7:0] acc_r [PARITY_MAX];
  logic [7:0] prod  [PARITY_MAX];
  logic [7:0] base;
  logic [7:0] log_base;
  logic [7:0] log_data;

  // Fragment index 255 wraps the base to zero.
  assign base     = frag + 8'd1;
  assign log_base = gfpe_pkg::LOG_TBL[base];
  assign log_data = gfpe_pkg::LOG_TBL[data];

  for (genvar p = 0; p < PARITY_MAX; p++) begin : g_lane
    gfpe_lane #(.LANE(p)) u_lane (
      .log_base  (log_base),
      .log_data  (log_data),
      .base_zero (base == 8'd0),
      .data_zero (data == 8'd0),
      .prod      (prod[p])
    );
    assign sum[p] = acc_r[p] ^ prod[p];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PARITY_MAX; p++) begin
        acc_r[p] <= 8'd0;
      end
    end else if (ctl.fire) begin
      for (int p = 0; p < PARITY_MAX; p++) begin
        acc_r[p] <= ctl.close ? 8'd0 : sum[p];
      end
    end
  end

endmodule

/* rtl/gfpe_drain.sv */
// Column result buffer and output register; sends one parity byte per cycle while out_tready is high.
// Depends on gfpe_pkg.
module gfpe_drain #(
  parameter int PARITY_MAX = gfpe_pkg::PARITY_MAX_DEF,
  parameter int CNT_W      = $clog2(PARITY_MAX + 1),
  parameter int LANE_W     = (PARITY_MAX > 1) ? $clog2(PARITY_MAX) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [gfpe_pkg::COL_W-1:0]     load_col,
  input  logic [CNT_W-1:0]               load_n,
  input  logic [7:0]                     load_bytes [PARITY_MAX],
  output logic                           busy,
  input  logic                           out_tready,
  output logic                           out_valid,
  output logic [gfpe_pkg::IDX_OUT_W-1:0] out_idx,
  output logic [gfpe_pkg::COL_W-1:0]     out_col,
  output logic [7:0]                     out_byte,
  output logic                           out_last
);

  logic [7:0]                     buf_r [PARITY_MAX];
  logic [gfpe_pkg::COL_W-1:0]     col_r;
  logic [CNT_W-1:0]               n_r;
  logic [LANE_W-1:0]              idx_r;
  logic                           busy_r;
  logic                           out_valid_r;
  logic [gfpe_pkg::IDX_OUT_W-1:0] out_idx_r;
  logic [gfpe_pkg::COL_W-1:0]     out_col_r;
  logic [7:0]                     out_byte_r;
  logic                           out_last_r;
  logic                           take;
  logic                           at_last;

  assign take    = busy_r && (!out_valid_r || out_tready);
  assign at_last = (CNT_W'(idx_r) + CNT_W'(1)) == n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (take) begin
        if (at_last) begin
          busy_r <= 1'b0;
          idx_r  <= '0;
        end else begin
          idx_r <= idx_r + LANE_W'(1);
        end
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int p = 0; p < PARITY_MAX; p++) begin
        buf_r[p] <= load_bytes[p];
      end
      col_r <= load_col;
      n_r   <= load_n;
    end
    if (take) begin
      out_idx_r  <= gfpe_pkg::IDX_OUT_W'(idx_r);
      out_col_r  <= col_r;
      out_byte_r <= buf_r[idx_r];
      out_last_r <= at_last;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_col   = out_col_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

/* rtl/gf256_erasure_parity_encoder.sv */
// A closing byte moves from the input register through the result buffer into the output
// register; its parity bytes leave one per cycle while out_tready is high.
// Throughput: one data byte per cycle. A closing byte waits in the input register only
// while the previous column's parity bytes are still leaving the result buffer.
// Reset (rst_n low, synchronous) clears all accumulators, empties both channels and sets
// the parity byte count to 1 and the block width to 1024.
module gf256_erasure_parity_encoder #(
  parameter int PARITY_MAX = gfpe_pkg::PARITY_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration writes: cfg_index selects the register, cfg_data carries the value.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gfpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gfpe_pkg::COL_W-1:0]        cfg_data,
  // Data byte stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata, low bit up: frag_index[7:0], column_index[23:8], data_byte[31:24]
  input  logic [31:0]                       in_tdata,
  // in_tuser: byte_present
  input  logic                              in_tuser,
  // in_tlast: last_in_column
  input  logic                              in_tlast,
  // Parity byte stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata, low bit up: lane number[3:0], column_out[19:4], parity_byte[27:20],
  // zero padding[31:28]
  output logic [31:0]                       out_tdata,
  // out_tlast: last_of_column
  output logic                              out_tlast
);

  localparam int CNT_W  = $clog2(PARITY_MAX + 1);
  localparam int LANE_W = (PARITY_MAX > 1) ? $clog2(PARITY_MAX) : 1;

  // Configuration registers. Writes are always taken; unknown indexes are dropped.
  logic [gfpe_pkg::PCNT_W-1:0] pcnt_r;
  logic [gfpe_pkg::COL_W-1:0]  bw_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= gfpe_pkg::PCNT_RESET;
      bw_r   <= gfpe_pkg::BW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gfpe_pkg::REG_LANE_COUNT:  pcnt_r <= cfg_data[gfpe_pkg::PCNT_W-1:0];
        gfpe_pkg::REG_BLOCK_WIDTH: bw_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Number of parity bytes per column, saturated to the number of lanes built.
  logic [CNT_W-1:0] n_sat;

  always_comb begin
    if (int'(pcnt_r) > PARITY_MAX) begin
      n_sat = CNT_W'(PARITY_MAX);
    end else begin
      n_sat = CNT_W'(pcnt_r);
    end
  end

  // Input register. Bytes whose column lies at or beyond block_width are accepted and
  // dropped here, together with their column-closing flag. An absent byte is stored
  // as zero so that it adds nothing, yet it may still close the column.
  logic                        a_valid_r;
  logic [gfpe_pkg::FRAG_W-1:0] a_frag_r;
  logic [gfpe_pkg::COL_W-1:0]  a_col_r;
  logic [gfpe_pkg::DATA_W-1:0] a_data_r;
  logic                        a_last_r;
  logic                        a_go;
  logic                        in_req;
  logic                        in_range;
  logic                        drain_busy;
  logic                        drain_load;

  assign in_range  = in_tdata[23:8] < bw_r;
  assign in_req    = in_tvalid && in_tready;
  // A close that produces results needs the result buffer; a close with a count of
  // zero only clears the accumulators.
  assign a_go      = a_valid_r && !(a_last_r && (n_sat != '0) && drain_busy);
  assign in_tready = !a_valid_r || a_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      a_frag_r <= in_tdata[7:0];
      a_col_r  <= in_tdata[23:8];
      a_data_r <= in_tuser ? in_tdata[31:24] : 8'd0;
      a_last_r <= in_tlast;
    end
  end

  // Accumulator bank: every lane multiplies and accumulates each byte, and the closing
  // byte's contribution is folded into the snapshot handed on.
  gfpe_pkg::acc_ctl_t acc_ctl;
  logic [7:0]         acc_sum [PARITY_MAX];

  assign acc_ctl.fire  = a_go;
  assign acc_ctl.close = a_last_r;

  gfpe_accum #(.PARITY_MAX(PARITY_MAX)) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .frag  (a_frag_r),
    .data  (a_data_r),
    .sum   (acc_sum)
  );

  // Result buffer takes the column snapshot and sends it out lane by lane, so the
  // next column accumulates while this one drains.
  logic [gfpe_pkg::IDX_OUT_W-1:0] o_idx;
  logic [gfpe_pkg::COL_W-1:0]     o_col;
  logic [7:0]                     o_byte;

  assign drain_load = a_go && a_last_r && (n_sat != '0);

  gfpe_drain #(
    .PARITY_MAX (PARITY_MAX),
    .CNT_W      (CNT_W),
    .LANE_W     (LANE_W)
  ) u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (drain_load),
    .load_col   (a_col_r),
    .load_n     (n_sat),
    .load_bytes (acc_sum),
    .busy       (drain_busy),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_idx    (o_idx),
    .out_col    (o_col),
    .out_byte   (o_byte),
    .out_last   (out_tlast)
  );

  assign out_tdata = {4'd0, o_byte, o_col, o_idx};

endmodule

/* rtl/gfpe_checker.sv */
// Port-level checker for the GF(2^8) erasure parity encoder, bound to the top level.
// Depends on gf256_erasure_parity_encoder_macros.svh.
`include "gf256_erasure_parity_encoder_macros.svh"

module gfpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // A stalled parity byte keeps its contents.
  `GFPE_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "parity byte changed while stalled")

  // Reset empties the result channel.
  `GFPE_ASSERT_RST(a_out_reset, clk, !rst_n |=> !out_tvalid, "result valid right after reset")

  // Within a column, the next lane follows at once with the same column.
  `GFPE_ASSERT(a_lane_order, clk, rst_n, out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tdata[3:0] == $past(out_tdata[3:0]) + 4'd1 && out_tdata[19:4] == $past(out_tdata[19:4]), "parity lanes out of order")

  // A new column always starts at lane zero.
  `GFPE_ASSERT(a_lane_start, clk, rst_n, out_tvalid && out_tready && out_tlast |=> !out_tvalid || out_tdata[3:0] == 4'd0, "column does not start at lane zero")

endmodule

bind gf256_erasure_parity_encoder gfpe_checker u_gfpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* dv/tb.sv */
// Self-checking testbench for the GF(2^8) erasure parity encoder. It drives data
// requests and register writes, predicts every parity request and checks it field by field.
// Depends on gfpe_pkg and the gf256_erasure_parity_encoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PARITY_LANES = 16;
  localparam int SETTLE_CYCLES = 10;
  localparam int TAIL_CYCLES = 20;
  localparam int STALL_LIMIT = 3000;
  localparam int PRESSURE_HOLD = 400;

  typedef struct {
    logic [7:0]  frag;
    logic [15:0] col;
    logic [7:0]  data;
    logic        present;
    logic        last;
  } data_req_t;

  typedef struct {
    logic [3:0]  lane;
    logic [15:0] col;
    logic [7:0]  pbyte;
    logic        last;
  } parity_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [gfpe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gfpe_pkg::COL_W-1:0]     cfg_data = '0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  gf256_erasure_parity_encoder #(
    .PARITY_MAX(PARITY_LANES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Shadow copy of the block: registers and one accumulator per parity lane.
  logic [4:0]  cfg_pcount = gfpe_pkg::PCNT_RESET;
  logic [15:0] cfg_width = gfpe_pkg::BW_RESET;
  logic [7:0]  lane_acc [PARITY_LANES];

  data_req_t   req_queue[$];
  parity_req_t parity_due[$];
  data_req_t   cur_req;

  int  errors = 0;
  bit  in_taken = 1'b0;
  int  in_gap = 0;
  int  out_hold = 0;
  bit  in_gaps_on = 1'b1;
  bit  out_stalls_on = 1'b1;
  bit  pressure_req = 1'b0;
  bit  pressure_seen = 1'b0;
  int  idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Carry-less multiply of two field elements, reduced by the field polynomial.
  function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] r;
    x = {1'b0, a};
    r = 8'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ x[7:0];
      end
      x = x << 1;
      if (x[8]) begin
        x = x ^ gfpe_pkg::GF_POLY;
      end
    end
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Folds one accepted data request into the lanes and queues the parity it releases.
  task automatic absorb_request(input data_req_t r);
    logic [7:0]  base;
    logic [7:0]  coef;
    int          n;
    parity_req_t p;
    if (r.col >= cfg_width) begin
      return;
    end
    if (r.present && r.data != 8'd0) begin
      // Fragment 255 wraps the base to zero, so only lane 0 sees the byte.
      base = r.frag + 8'd1;
      coef = 8'd1;
      for (int k = 0; k < PARITY_LANES; k++) begin
        lane_acc[k] = lane_acc[k] ^ gf_product(coef, r.data);
        coef = gf_product(coef, base);
      end
    end
    if (!r.last) begin
      return;
    end
    n = (cfg_pcount > PARITY_LANES) ? PARITY_LANES : int'(cfg_pcount);
    for (int k = 0; k < n; k++) begin
      p.lane  = 4'(k);
      p.col   = r.col;
      p.pbyte = lane_acc[k];
      p.last  = (k + 1 == n);
      parity_due.insert(parity_due.size(), p);
    end
    for (int k = 0; k < PARITY_LANES; k++) begin
      lane_acc[k] = 8'd0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got 'h%0h, predicted 'h%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Input side: acceptance and prediction at the rising edge.
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      absorb_request(cur_req);
    end
  end

  // Driver: a new request or a gap is set up at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (req_queue.size() > 0) begin
        cur_req = req_queue.pop_front();
        in_tdata <= {cur_req.data, cur_req.col, cur_req.frag};
        in_tuser <= cur_req.present;
        in_tlast <= cur_req.last;
        in_tvalid <= 1'b1;
        in_gap = in_gaps_on ? pick_gap() : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (pressure_req && !pressure_seen) begin
      pressure_seen = 1'b1;
      out_hold = PRESSURE_HOLD - 1;
      out_tready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold = out_hold - 1;
      out_tready <= 1'b0;
    end else if (out_stalls_on && $urandom_range(0, 99) < 25) begin
      out_hold = pick_gap();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: every accepted parity request against the oldest prediction.
  always @(posedge clk) begin
    parity_req_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (parity_due.size() == 0) begin
        report_mismatch("unpredicted parity request", out_tdata, 32'd0);
      end else begin
        want = parity_due.pop_front();
        if (out_tdata[3:0] != want.lane) begin
          report_mismatch("lane number", 32'(out_tdata[3:0]), 32'(want.lane));
        end
        if (out_tdata[19:4] != want.col) begin
          report_mismatch("column_out", 32'(out_tdata[19:4]), 32'(want.col));
        end
        if (out_tdata[27:20] != want.pbyte) begin
          report_mismatch("parity_byte", 32'(out_tdata[27:20]), 32'(want.pbyte));
        end
        if (out_tdata[31:28] != 4'd0) begin
          report_mismatch("tdata padding", 32'(out_tdata[31:28]), 32'd0);
        end
        if (out_tlast != want.last) begin
          report_mismatch("last_of_column", 32'(out_tlast), 32'(want.last));
        end
      end
    end
  end

  // Watchdog: too long without any handshake on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t no handshake for %0d cycles", $realtime, STALL_LIMIT);
        $display("[gf256_erasure_parity_encoder] ERROR");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [gfpe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    if (idx == gfpe_pkg::REG_LANE_COUNT) begin
      cfg_pcount = value[4:0];
    end else if (idx == gfpe_pkg::REG_BLOCK_WIDTH) begin
      cfg_width = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_req(input logic [7:0] frag, input logic [15:0] col,
                          input logic [7:0] data, input logic present, input logic last);
    data_req_t r;
    r.frag = frag;
    r.col = col;
    r.data = data;
    r.present = present;
    r.last = last;
    req_queue.insert(req_queue.size(), r);
  endtask

  // Waits until every request is in and every parity request is out, then lets
  // a non-closing request still inside the block settle.
  task automatic drain();
    while (req_queue.size() != 0 || in_tvalid || parity_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_column();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return 16'd0;
    end else if (r < 20) begin
      return cfg_width - 16'd1;
    end
    return 16'($urandom_range(0, int'(cfg_width) - 1));
  endfunction

  // Mostly whole columns with random content; the rest is loose noise that
  // may fall out of range, mix columns or close early.
  task automatic gen_traffic(input int want);
    int          pushed;
    int          nfrag;
    logic [7:0]  base_frag;
    logic [15:0] col;
    data_req_t   r;
    pushed = 0;
    while (pushed < want) begin
      if ($urandom_range(0, 99) < 85) begin
        nfrag = $urandom_range(1, 10);
        base_frag = 8'($urandom_range(0, 245));
        col = pick_column();
        for (int k = 0; k < nfrag; k++) begin
          r.frag = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : base_frag + 8'(k);
          r.col = ($urandom_range(0, 19) == 0) ? pick_column() : col;
          r.data = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
          r.present = ($urandom_range(0, 9) != 0);
          r.last = (k == nfrag - 1);
          req_queue.insert(req_queue.size(), r);
          pushed++;
        end
      end else begin
        r.frag = 8'($urandom_range(0, 255));
        r.col = 16'($urandom_range(0, 65535));
        r.data = 8'($urandom_range(0, 255));
        r.present = 1'($urandom_range(0, 1));
        r.last = 1'($urandom_range(0, 1));
        req_queue.insert(req_queue.size(), r);
        if (r.col < cfg_width) begin
          pushed++;
        end
      end
    end
  endtask

  initial begin
    for (int k = 0; k < PARITY_LANES; k++) begin
      lane_acc[k] = 8'd0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: one lane, width 1024; the top column just in range.
    push_req(8'd0, 16'd0, 8'hA5, 1'b1, 1'b0);
    push_req(8'd1, 16'd0, 8'h3C, 1'b1, 1'b1);
    push_req(8'd3, 16'd1024, 8'h77, 1'b1, 1'b1);
    push_req(8'd2, 16'd1023, 8'hFF, 1'b1, 1'b1);
    drain();

    // All sixteen lanes, width 0xFFFF: a column 0xFFFF with fragment 255 and an absent
    // closing byte, dropped as out of range; then mixed columns and a zero data byte.
    reg_write(gfpe_pkg::REG_LANE_COUNT, 16'd16);
    reg_write(gfpe_pkg::REG_BLOCK_WIDTH, 16'hFFFF);
    push_req(8'd0, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
    push_req(8'd254, 16'hFFFF, 8'h80, 1'b1, 1'b0);
    push_req(8'd255, 16'hFFFF, 8'h5A, 1'b1, 1'b0);
    push_req(8'd7, 16'hFFFF, 8'h12, 1'b0, 1'b1);
    push_req(8'd3, 16'd10, 8'h01, 1'b1, 1'b0);
    push_req(8'd4, 16'd20, 8'h02, 1'b1, 1'b1);
    push_req(8'd5, 16'd30, 8'h00, 1'b1, 1'b1);
    drain();

    // No lanes and width 1: a close emits nothing but still clears the lanes.
    reg_write(gfpe_pkg::REG_LANE_COUNT, 16'd0);
    reg_write(gfpe_pkg::REG_BLOCK_WIDTH, 16'd1);
    push_req(8'd9, 16'd0, 8'h55, 1'b1, 1'b1);
    push_req(8'd9, 16'd1, 8'h44, 1'b1, 1'b1);
    drain();

    // A count above the lane total saturates; the lanes must start from zero.
    reg_write(gfpe_pkg::REG_LANE_COUNT, 16'd31);
    push_req(8'd1, 16'd0, 8'h01, 1'b1, 1'b1);
    drain();

    // Upper data bits of the count write are dropped, leaving three lanes.
    reg_write(gfpe_pkg::REG_LANE_COUNT, 16'hFFE3);
    reg_write(gfpe_pkg::REG_BLOCK_WIDTH, 16'h8000);
    push_req(8'd200, 16'h7FFF, 8'hC3, 1'b1, 1'b0);
    push_req(8'd17, 16'h8000, 8'h11, 1'b1, 1'b1);
    push_req(8'd0, 16'd0, 8'h01, 1'b1, 1'b1);
    drain();

    // Random phases. The second one runs against a long receiver hold-off.
    reg_write(gfpe_pkg::REG_LANE_COUNT, 16'd1);
    reg_write(gfpe_pkg::REG_BLOCK_WIDTH, 16'd1);
    gen_traffic(50);
    drain();

    reg_write(gfpe_pkg::REG_LANE_COUNT, 16'd16);
    reg_write(gfpe_pkg::REG_BLOCK_WIDTH, 16'hFFFF);
    in_gaps_on = 1'b0;
    pressure_req = 1'b1;
    gen_traffic(70);
    drain();

    out_stalls_on = 1'b0;
    reg_write(gfpe_pkg::REG_LANE_COUNT, 16'($urandom_range(0, 31)));
    reg_write(gfpe_pkg::REG_BLOCK_WIDTH, 16'($urandom_range(1, 65535)));
    gen_traffic(60);
    drain();

    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    reg_write(gfpe_pkg::REG_LANE_COUNT, 16'd2);
    reg_write(gfpe_pkg::REG_BLOCK_WIDTH, 16'd300);
    gen_traffic(70);
    drain();

    reg_write(gfpe_pkg::REG_LANE_COUNT, 16'($urandom_range(1, 16)));
    reg_write(gfpe_pkg::REG_BLOCK_WIDTH, 16'($urandom_range(1, 65535)));
    gen_traffic(70);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && parity_due.size() == 0) begin
      $display("[gf256_erasure_parity_encoder] OK");
    end else begin
      $display("[gf256_erasure_parity_encoder] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/gfpe_pkg.sv
rtl/gfpe_lane.sv
rtl/gfpe_accum.sv
rtl/gfpe_drain.sv
rtl/gf256_erasure_parity_encoder.sv
rtl/gfpe_checker.sv
dv/tb.sv
